// ===== rtl/hqc_pkg.sv =====
// ----------------------------------------------------------------------------
// hqc_pkg
// shared types, constants, rounding and saturation helpers of the quaternion curve block
// ----------------------------------------------------------------------------
package hqc_pkg;

  // Q28 working value, room for the +-8.0 clamp and sign
  typedef logic signed [33:0] fx_t;
  // wide accumulator for products and sums of products
  typedef logic signed [71:0] wide_t;
  // quaternion lanes w,x,y,z at indexes 0..3
  typedef fx_t [3:0] quat_t;

  typedef enum logic [7:0] {
    REG_START  = 8'd0,
    REG_ROT1   = 8'd1,
    REG_ROT2   = 8'd2,
    REG_ROT3   = 8'd3
  } reg_idx_t;

  localparam fx_t   Q_ONE     = 34'sd268435456;
  localparam wide_t MID_LIMIT = 72'sd2147483648;
  localparam int unsigned STEPS = 8;

  // round half away from zero, then shift right by n
  function automatic wide_t rnd_sh(input wide_t v, input int unsigned n);
    logic [71:0] m;
    m = v[71] ? 72'(-v) : 72'(v);
    m = (m + (72'd1 << (n - 1))) >> n;
    return v[71] ? -wide_t'(m) : wide_t'(m);
  endfunction

  function automatic fx_t sat_mid(input wide_t v);
    if (v > MID_LIMIT) return fx_t'(MID_LIMIT);
    if (v < -MID_LIMIT) return fx_t'(-MID_LIMIT);
    return fx_t'(v);
  endfunction

endpackage

// ===== rtl/hqc_horner_cell.sv =====
// ----------------------------------------------------------------------------
// hqc_horner_cell
// one horner step of the sine and cosine series: acc = 1 - round(x2*acc / div)
// ----------------------------------------------------------------------------
module hqc_horner_cell import hqc_pkg::*; #(
  parameter int unsigned DIV_S = 2,
  parameter int unsigned DIV_C = 2
) (
  input  logic clk,
  input  logic en,
  input  fx_t  x2_i,
  input  fx_t  s_i,
  input  fx_t  c_i,
  output fx_t  x2_o,
  output fx_t  s_o,
  output fx_t  c_o
);

  localparam logic [33:0] DV [2] = '{34'(DIV_S), 34'(DIV_C)};
  // reciprocal scaled by 2^33, quotient is low by at most one
  localparam logic [33:0] RC [2] = '{34'((64'd1 << 33) / DIV_S),
                                     34'((64'd1 << 33) / DIV_C)};

  fx_t         x2_r   [4];
  wide_t       prod_r [2];
  logic        neg1_r [2];
  logic        neg2_r [2];
  logic [33:0] mag1_r [2];
  logic [33:0] mag2_r [2];
  logic [33:0] q0_r   [2];
  fx_t         res_r  [2];

  wide_t       v_c   [2];
  logic [71:0] abs_c [2];
  logic [67:0] qp_c  [2];
  logic [33:0] rem_c [2];
  logic [33:0] q_c   [2];

  always_comb begin
    for (int j = 0; j < 2; j++) begin
      v_c[j]   = rnd_sh(prod_r[j], 28);
      abs_c[j] = v_c[j][71] ? 72'(-v_c[j]) : 72'(v_c[j]);
      qp_c[j]  = 68'(mag1_r[j]) * 68'(RC[j]);
      rem_c[j] = mag2_r[j] - 34'(q0_r[j] * DV[j]);
      q_c[j]   = (rem_c[j] >= DV[j]) ? q0_r[j] + 34'd1 : q0_r[j];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x2_r[0] <= x2_i;
      for (int k = 1; k < 4; k++) x2_r[k] <= x2_r[k-1];
      prod_r[0] <= wide_t'(x2_i) * wide_t'(s_i);
      prod_r[1] <= wide_t'(x2_i) * wide_t'(c_i);
      for (int j = 0; j < 2; j++) begin
        neg1_r[j] <= v_c[j][71];
        mag1_r[j] <= abs_c[j][33:0] + (DV[j] >> 1);
        q0_r[j]   <= qp_c[j][66:33];
        mag2_r[j] <= mag1_r[j];
        neg2_r[j] <= neg1_r[j];
        res_r[j]  <= Q_ONE - (neg2_r[j] ? -fx_t'(q_c[j]) : fx_t'(q_c[j]));
      end
    end
  end

  assign x2_o = x2_r[3];
  assign s_o  = res_r[0];
  assign c_o  = res_r[1];

endmodule

// ===== rtl/hqc_rot_lane.sv =====
// ----------------------------------------------------------------------------
// hqc_rot_lane
// scaled angle-axis word to rotation quaternion, 40 pipeline stages
// ----------------------------------------------------------------------------
module hqc_rot_lane import hqc_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [42:0] basis_i,
  input  logic [63:0] word_i,
  output quat_t       q_o
);

  localparam int unsigned CELL_LAT = 4 * STEPS;

  logic [58:0] p_r;
  fx_t         h_r, ha_r, hb_r;
  wide_t       hh_r;
  fx_t         x2_r;
  fx_t         hd_r [CELL_LAT];
  wide_t       sp_r;
  fx_t         sn_r;
  wide_t       ap_r [3];
  fx_t         rc1_r, rc2_r, rc3_r;
  quat_t       q_r;

  fx_t x2_w [STEPS+1];
  fx_t s_w  [STEPS+1];
  fx_t c_w  [STEPS+1];

  assign x2_w[0] = x2_r;
  assign s_w[0]  = Q_ONE;
  assign c_w[0]  = Q_ONE;

  // series constants run from the highest term down
  for (genvar n = 0; n < STEPS; n++) begin : g_cell
    localparam int unsigned K = STEPS - n;
    hqc_horner_cell #(
      .DIV_S((2 * K) * (2 * K + 1)),
      .DIV_C((2 * K - 1) * (2 * K))
    ) u_cell (
      .clk (clk),
      .en  (en),
      .x2_i(x2_w[n]),
      .s_i (s_w[n]),
      .c_i (c_w[n]),
      .x2_o(x2_w[n+1]),
      .s_o (s_w[n+1]),
      .c_o (c_w[n+1])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r  <= 59'(word_i[15:0]) * 59'(basis_i);
      h_r  <= fx_t'((p_r + 59'(64'd1 << 28)) >> 29);
      hh_r <= wide_t'(h_r) * wide_t'(h_r);
      ha_r <= h_r;
      x2_r <= fx_t'(rnd_sh(hh_r, 28));
      hb_r <= ha_r;
      hd_r[0] <= hb_r;
      for (int k = 1; k < CELL_LAT; k++) hd_r[k] <= hd_r[k-1];
      sp_r  <= wide_t'(hd_r[CELL_LAT-1]) * wide_t'(s_w[STEPS]);
      rc1_r <= c_w[STEPS];
      sn_r  <= fx_t'(rnd_sh(sp_r, 28));
      rc2_r <= rc1_r;
      for (int i = 0; i < 3; i++)
        ap_r[i] <= wide_t'($signed(word_i[16*(i+1) +: 16])) * wide_t'(sn_r);
      rc3_r <= rc2_r;
      q_r[0] <= rc3_r;
      for (int i = 0; i < 3; i++) q_r[i+1] <= fx_t'(rnd_sh(ap_r[i], 14));
    end
  end

  assign q_o = q_r;

endmodule

// ===== rtl/hqc_qmul.sv =====
// ----------------------------------------------------------------------------
// hqc_qmul
// hamilton product r = a * b in Q28, three stages, clamped to +-8.0
// ----------------------------------------------------------------------------
module hqc_qmul import hqc_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  quat_t a_i,
  input  quat_t b_i,
  output quat_t r_o
);

  wide_t prod_r [4][4];
  wide_t sum_r  [4];
  quat_t r_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++)
        for (int j = 0; j < 4; j++)
          prod_r[i][j] <= wide_t'($signed(a_i[i])) * wide_t'($signed(b_i[j]));
      sum_r[0] <= prod_r[0][0] - prod_r[1][1] - prod_r[2][2] - prod_r[3][3];
      sum_r[1] <= prod_r[0][1] + prod_r[1][0] + prod_r[2][3] - prod_r[3][2];
      sum_r[2] <= prod_r[0][2] - prod_r[1][3] + prod_r[2][0] + prod_r[3][1];
      sum_r[3] <= prod_r[0][3] + prod_r[1][2] - prod_r[2][1] + prod_r[3][0];
      for (int i = 0; i < 4; i++) r_r[i] <= sat_mid(rnd_sh(sum_r[i], 28));
    end
  end

  assign r_o = r_r;

endmodule

// ===== rtl/hermite_quaternion_curve_eval.sv =====
// ----------------------------------------------------------------------------
// hermite_quaternion_curve_eval
// cumulative hermite quaternion curve eval, one parameter per unstalled cycle
// ----------------------------------------------------------------------------
// Usage:
//   cfg channel writes start_quat (index 0) and the three angle-axis words
//   (index 1..3); cfg_ready is always high, other indexes are dropped.
//   Write configuration only while no transaction is in flight.
//   in channel takes one curve parameter per transaction; out channel
//   returns the quaternion out_w..out_z for each, in order.
//   out_valid rises after the 53 register stages; unless the output stalls,
//   throughput is one transaction per cycle, set by the 53-stage pipeline
//   (3 basis stages, three parallel 40-stage rotation lanes with eight
//   series cells each, three 3-stage quaternion products and the output
//   register) all advancing on one enable.
//   When the receiver stalls a valid output, the whole pipeline holds and
//   in_ready drops in the same cycle; it stays high while out_ready is high.
//   Reset empties the pipeline and restores identity start, zero rotations.
// ----------------------------------------------------------------------------
module hermite_quaternion_curve_eval import hqc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] in_param_s,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_w,
  output logic signed [15:0] out_x,
  output logic signed [15:0] out_y,
  output logic signed [15:0] out_z,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [63:0]        cfg_data
);

  localparam int unsigned LAT = 53;

  logic [63:0] start_r, rot1_r, rot2_r, rot3_r;
  logic [LAT-1:0] vld_r;
  logic adv;

  logic [14:0] su_r, su1_r, t_r;
  logic [28:0] su2_r, t2_r;
  logic [42:0] b_r [3];
  quat_t rq_w [3];
  quat_t acc_w, m1_w, m2_w, m3_w;
  quat_t r2d_r [3];
  quat_t r3d_r [6];
  logic signed [15:0] o_r [4];

  assign adv       = !vld_r[LAT-1] || out_ready;
  assign in_ready  = adv;
  assign cfg_ready = 1'b1;
  assign out_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= 64'd16384;
      rot1_r  <= '0;
      rot2_r  <= '0;
      rot3_r  <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_START: start_r <= cfg_data;
        REG_ROT1:  rot1_r  <= cfg_data;
        REG_ROT2:  rot2_r  <= cfg_data;
        REG_ROT3:  rot3_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // basis stages
  always_ff @(posedge clk) begin
    if (adv) begin
      if (in_param_s[15]) su_r <= '0;
      else if (in_param_s > 16'sd16384) su_r <= 15'd16384;
      else su_r <= in_param_s[14:0];
      t_r   <= 15'd16384 - su_r;
      su1_r <= su_r;
      su2_r <= 29'(su_r) * 29'(su_r);
      t2_r  <= 29'(15'd16384 - su_r) * 29'(15'd16384 - su_r);
      b_r[0] <= (43'd1 << 42) - 43'(45'(t2_r) * 45'(t_r));
      b_r[1] <= 43'(45'(su2_r) * 45'(17'd49152 - {su1_r, 1'b0}));
      b_r[2] <= 43'(45'(su2_r) * 45'(su1_r));
    end
  end

  hqc_rot_lane u_lane1 (.clk(clk), .en(adv), .basis_i(b_r[0]), .word_i(rot1_r),
                        .q_o(rq_w[0]));
  hqc_rot_lane u_lane2 (.clk(clk), .en(adv), .basis_i(b_r[1]), .word_i(rot2_r),
                        .q_o(rq_w[1]));
  hqc_rot_lane u_lane3 (.clk(clk), .en(adv), .basis_i(b_r[2]), .word_i(rot3_r),
                        .q_o(rq_w[2]));

  always_comb begin
    for (int i = 0; i < 4; i++)
      acc_w[i] = fx_t'($signed({start_r[16*i +: 16], 14'd0}));
  end

  // later rotations wait for the product chain
  always_ff @(posedge clk) begin
    if (adv) begin
      r2d_r[0] <= rq_w[1];
      for (int k = 1; k < 3; k++) r2d_r[k] <= r2d_r[k-1];
      r3d_r[0] <= rq_w[2];
      for (int k = 1; k < 6; k++) r3d_r[k] <= r3d_r[k-1];
    end
  end

  hqc_qmul u_mul1 (.clk(clk), .en(adv), .a_i(acc_w), .b_i(rq_w[0]),  .r_o(m1_w));
  hqc_qmul u_mul2 (.clk(clk), .en(adv), .a_i(m1_w),  .b_i(r2d_r[2]), .r_o(m2_w));
  hqc_qmul u_mul3 (.clk(clk), .en(adv), .a_i(m2_w),  .b_i(r3d_r[5]), .r_o(m3_w));

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        if (rnd_sh(wide_t'($signed(m3_w[i])), 14) > 72'sd32767)
          o_r[i] <= 16'sd32767;
        else if (rnd_sh(wide_t'($signed(m3_w[i])), 14) < -72'sd32768)
          o_r[i] <= -16'sd32768;
        else
          o_r[i] <= 16'(rnd_sh(wide_t'($signed(m3_w[i])), 14));
      end
    end
  end

  assign out_w = o_r[0];
  assign out_x = o_r[1];
  assign out_y = o_r[2];
  assign out_z = o_r[3];

endmodule

// ===== rtl/hqc_checker.sv =====
// ----------------------------------------------------------------------------
// hqc_checker
// port-level checks of the quaternion curve evaluator
// ----------------------------------------------------------------------------
module hqc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic signed [15:0] in_param_s,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] out_w,
  input logic signed [15:0] out_x,
  input logic signed [15:0] out_y,
  input logic signed [15:0] out_z,
  input logic               cfg_valid,
  input logic               cfg_ready,
  input logic [7:0]         cfg_index,
  input logic [63:0]        cfg_data
);

  // a stalled result transaction stays
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("out_valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_w) && $stable(out_x) &&
    $stable(out_y) && $stable(out_z))
    else $error("result changed while stalled");

  // pipeline empty right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // input side advances exactly when the output side can move
  a_ready_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready out of step with output");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind hermite_quaternion_curve_eval hqc_checker u_hqc_checker (.*);

// ===== dv/tb_hermite_quaternion_curve_eval.sv =====
// ----------------------------------------------------------------------------
// tb_hermite_quaternion_curve_eval
// self-checking bench: each accepted curve parameter is run through a
// fixed-point quaternion curve predictor and compared with the block output
// ----------------------------------------------------------------------------
module tb_hermite_quaternion_curve_eval;
  import hqc_pkg::*;

  typedef struct {
    logic signed [15:0] w;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } quat_out_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic signed [15:0] in_param_s;
  logic               out_valid;
  logic               out_ready;
  logic signed [15:0] out_w;
  logic signed [15:0] out_x;
  logic signed [15:0] out_y;
  logic signed [15:0] out_z;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [7:0]         cfg_index;
  logic [63:0]        cfg_data;

  // shadow copy of the configuration registers
  logic [63:0] start_word;
  logic [63:0] rot_word [1:3];

  quat_out_t expected_quats[$];
  int n_err;
  int n_checked;
  int n_sent;
  int n_cfg;
  int long_hold;

  hermite_quaternion_curve_eval dut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("tb_hermite_quaternion_curve_eval failed");
    $finish;
  end

  // ---------------------------------------------------------------- predictor
  function automatic longint rnd_shift(input longint v, input int n);
    longint unsigned m;
    m = v < 0 ? longint'(-v) : v;
    m = (m + (64'd1 << (n - 1))) >> n;
    return v < 0 ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint rnd_div(input longint v, input longint d);
    longint m;
    m = v < 0 ? -v : v;
    m = (m + d / 2) / d;
    return v < 0 ? -m : m;
  endfunction

  function automatic longint q28_mul(input longint a, input longint b);
    return rnd_shift(a * b, 28);
  endfunction

  function automatic longint lane_of(input logic [63:0] word, input int i);
    return longint'(signed'(word[16*i +: 16]));
  endfunction

  function automatic longint clamp_mid(input longint v);
    if (v > 64'sd2147483648) return 64'sd2147483648;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  task automatic hamilton(input longint a[4], input longint b[4], output longint r[4]);
    longint t[4];
    t[0] = a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3];
    t[1] = a[0]*b[1] + a[1]*b[0] + a[2]*b[3] - a[3]*b[2];
    t[2] = a[0]*b[2] - a[1]*b[3] + a[2]*b[0] + a[3]*b[1];
    t[3] = a[0]*b[3] + a[1]*b[2] - a[2]*b[1] + a[3]*b[0];
    for (int i = 0; i < 4; i++) r[i] = clamp_mid(rnd_shift(t[i], 28));
  endtask

  // angle-axis word scaled by a Q42 basis value -> rotation quaternion in Q28
  task automatic axis_angle_quat(input logic [63:0] word, input longint basis,
                                 output longint q[4]);
    longint h, h2, s_acc, c_acc, sn;
    h = rnd_shift(longint'(word[15:0]) * basis, 29);
    h2 = q28_mul(h, h);
    s_acc = 64'sd268435456;
    c_acc = 64'sd268435456;
    for (int k = STEPS; k >= 1; k--) begin
      s_acc = 64'sd268435456 - rnd_div(q28_mul(h2, s_acc), (2*k) * (2*k + 1));
      c_acc = 64'sd268435456 - rnd_div(q28_mul(h2, c_acc), (2*k - 1) * (2*k));
    end
    sn = q28_mul(h, s_acc);
    q[0] = c_acc;
    for (int i = 1; i < 4; i++) q[i] = q28_mul(lane_of(word, i) * 16384, sn);
  endtask

  task automatic predict_curve_quat(input logic signed [15:0] s_in, output quat_out_t res);
    longint s, t, b[1:3], acc[4], rq[4], tmp[4], v[4];
    s = s_in;
    if (s < 0) s = 0;
    if (s > 16384) s = 16384;
    t = 16384 - s;
    b[1] = (64'sd1 <<< 42) - t * t * t;
    b[2] = s * s * (3 * 16384 - 2 * s);
    b[3] = s * s * s;
    for (int i = 0; i < 4; i++) acc[i] = lane_of(start_word, i) * 16384;
    for (int r = 1; r <= 3; r++) begin
      axis_angle_quat(rot_word[r], b[r], rq);
      hamilton(acc, rq, tmp);
      acc = tmp;
    end
    for (int i = 0; i < 4; i++) begin
      v[i] = rnd_shift(acc[i], 14);
      if (v[i] > 32767) v[i] = 32767;
      if (v[i] < -32768) v[i] = -32768;
    end
    res.w = v[0][15:0];
    res.x = v[1][15:0];
    res.y = v[2][15:0];
    res.z = v[3][15:0];
  endtask

  // ------------------------------------------------------------ monitors
  always @(posedge clk) begin
    quat_out_t e;
    if (rst_n && in_valid && in_ready) begin
      predict_curve_quat(in_param_s, e);
      expected_quats.push_back(e);
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    n_err++;
  endtask

  always @(posedge clk) begin
    quat_out_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_quats.size() == 0) begin
        report_mismatch("unexpected transaction", 1, 0);
      end else begin
        e = expected_quats.pop_front();
        n_checked++;
        if (out_w !== e.w) report_mismatch("out_w", out_w, e.w);
        if (out_x !== e.x) report_mismatch("out_x", out_x, e.x);
        if (out_y !== e.y) report_mismatch("out_y", out_y, e.y);
        if (out_z !== e.z) report_mismatch("out_z", out_z, e.z);
      end
    end
  end

  // receiver: random stalls, plus a long hold-off when requested
  initial begin
    int n;
    out_ready = 1'b1;
    forever begin
      if (long_hold > 0) begin
        n = long_hold;
        long_hold = 0;
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 3) != 0);
        n = ($urandom_range(0, 9) < 9) ? $urandom_range(1, 3) : $urandom_range(8, 30);
        repeat (n) @(posedge clk);
      end
    end
  end

  // ------------------------------------------------------------ drivers
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 19) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_param(input logic signed [15:0] s);
    int gap;
    in_valid   <= 1'b1;
    in_param_s <= s;
    do @(posedge clk); while (!in_ready);
    n_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_quats.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    n_cfg++;
    case (idx)
      REG_START: start_word  = data;
      REG_ROT1:  rot_word[1] = data;
      REG_ROT2:  rot_word[2] = data;
      REG_ROT3:  rot_word[3] = data;
      default: ;
    endcase
  endtask

  function automatic logic [15:0] axis_lane();
    return 16'($signed($urandom_range(0, 32768)) - 16384);
  endfunction

  function automatic logic [63:0] plausible_rot();
    return {axis_lane(), axis_lane(), axis_lane(), 16'($urandom_range(0, 65535))};
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic signed [15:0] rand_param();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return 16'($urandom_range(0, 16384));
    if (r < 9) return 16'($signed($urandom_range(0, 4000)) - 2000 + (r == 8 ? 16384 : 0));
    return 16'($urandom());
  endfunction

  // ------------------------------------------------------------ tests
  task automatic test_reset_identity();
    send_param(16'sd0);
    send_param(16'sd8192);
    send_param(16'sd16384);
    drain();
  endtask

  task automatic test_directed_corners();
    logic signed [15:0] pts[12];
    pts = '{-16'sd32768, -16'sd1, 16'sd0, 16'sd1, 16'sd8192, 16'sd16383,
            16'sd16384, 16'sd16385, 16'sd32767, 16'sh5555, -16'sh5556, 16'sd4096};
    // unit axes on all three rotations, full angles on the first two and a half angle on the third
    write_reg(REG_START, 64'h0000_0000_0000_2d41 | (64'h2d41 << 16));
    write_reg(REG_ROT1, {16'h0, 16'h0, 16'h4000, 16'hffff});
    write_reg(REG_ROT2, {16'h4000, 16'h0, 16'h0, 16'hffff});
    write_reg(REG_ROT3, {16'h0, 16'hc000, 16'h0, 16'h8000});
    foreach (pts[i]) send_param(pts[i]);
    drain();
    // oversized axis and start lanes push the products into saturation
    write_reg(REG_START, 64'h7fff_8000_7fff_7fff);
    write_reg(REG_ROT1, 64'h7fff_7fff_7fff_ffff);
    write_reg(REG_ROT2, 64'h8000_8000_8000_ffff);
    write_reg(REG_ROT3, 64'h7fff_8000_7fff_c000);
    send_param(16'sd0);
    send_param(16'sd8192);
    send_param(16'sd16384);
    drain();
    // writes to indexes past the last register are dropped
    write_reg(8'd4, 64'hffff_ffff_ffff_ffff);
    write_reg(8'd255, 64'h0);
    send_param(16'sd12000);
    send_param(16'sd16384);
    drain();
  endtask

  task automatic test_random_phases();
    for (int ph = 0; ph < 6; ph++) begin
      if (ph % 3 == 2) begin
        write_reg(REG_START, rand64());
        write_reg(REG_ROT1, rand64());
        write_reg(REG_ROT2, rand64());
        write_reg(REG_ROT3, rand64());
      end else begin
        write_reg(REG_START, {axis_lane(), axis_lane(), axis_lane(), axis_lane()});
        write_reg(REG_ROT1, plausible_rot());
        write_reg(REG_ROT2, plausible_rot());
        write_reg(REG_ROT3, (ph == 3) ? 64'h0 : plausible_rot());
      end
      repeat (250) send_param(rand_param());
      drain();
    end
  endtask

  task automatic test_output_backpressure();
    long_hold = 300;
    repeat (150) send_param(rand_param());
    drain();
  endtask

  task automatic test_pause_until_empty();
    repeat (40) send_param(rand_param());
    drain();
    repeat (40) send_param(rand_param());
    drain();
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_param_s = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    start_word = 64'd16384;
    rot_word[1] = '0;
    rot_word[2] = '0;
    rot_word[3] = '0;
    long_hold  = 0;
    n_err = 0;
    n_checked = 0;
    n_sent = 0;
    n_cfg = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_identity();
    test_directed_corners();
    test_random_phases();
    test_output_backpressure();
    test_pause_until_empty();

    $display("covered %0d parameter transactions, %0d register writes, %0d results checked",
             n_sent, n_cfg, n_checked);
    $display("clamped, saturating and random rotation settings, long output stall included");
    if (n_err == 0) begin
      $display("tb_hermite_quaternion_curve_eval passed");
    end else begin
      $display("tb_hermite_quaternion_curve_eval failed");
    end
    $finish;
  end

endmodule
